FILE: sv/rmfw_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizing constants of the recursive lock unit.
// No dependencies; every other file of the block but rmfw_ram imports this package.
package rmfw_pkg;

   localparam int QUEUE_DEPTH    = 1024;
   localparam int THREAD_ID_BITS = 10;
   localparam int NEST_BITS      = 8;
   localparam int MODE_BITS      = 2;
   localparam int PTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS       = $clog2(QUEUE_DEPTH + 1);

   // Bit of mode that selects unlock; the top code therefore also unlocks.
   localparam int UNLOCK_BIT = 1;

   localparam logic [MODE_BITS-1:0] MODE_LOCK = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TRY  = 2'd1;

   typedef logic [THREAD_ID_BITS-1:0] tid_type;
   typedef logic [PTR_BITS-1:0]       ptr_type;
   typedef logic [CNT_BITS-1:0]       cnt_type;
   typedef logic [NEST_BITS-1:0]      nest_type;

   typedef enum logic [3:0] {
      ST_ACQUIRED   = 4'd0,
      ST_NESTED     = 4'd1,
      ST_QUEUED     = 4'd2,
      ST_BUSY       = 4'd3,
      ST_FULL       = 4'd4,
      ST_RELEASED   = 4'd5,
      ST_DROPPED    = 4'd6,
      ST_NOT_LOCKED = 4'd7,
      ST_NOT_OWNER  = 4'd8,
      ST_SATURATED  = 4'd9
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      tid_type              thread_id;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       woken_valid;
      tid_type    woken_thread;
      cnt_type    waiters_now;
   } rsp_type;

   typedef struct packed {
      logic    wr_en;
      ptr_type wr_addr;
      tid_type wr_data;
      logic    rd_en;
      ptr_type rd_addr;
   } ring_cmd_type;

   function automatic ptr_type ring_next(input ptr_type p);
      return (p == ptr_type'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_type'(1);
   endfunction

endpackage

FILE: sv/rmfw_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
// Depends on rmfw_pkg for field types.
interface rmfw_req_if;
   import rmfw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   tid_type              thread_id;

   modport source (output valid, output mode, output thread_id, input ready);
   modport sink   (input valid, input mode, input thread_id, output ready);
endinterface

interface rmfw_rsp_if;
   import rmfw_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   logic       woken_valid;
   tid_type    woken_thread;
   cnt_type    waiters_now;

   modport source (output valid, output status, output woken_valid,
                   output woken_thread, output waiters_now, input ready);
   modport sink   (input valid, input status, input woken_valid,
                   input woken_thread, input waiters_now, output ready);
endinterface

FILE: sv/rmfw_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rmfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/rmfw_ctrl.sv
`timescale 1ns / 1ps
// Lock sequencer: owner, nesting and queue pointers, plus the decision logic.
// Depends on rmfw_pkg; drives the wait ring memory through a command struct.
module rmfw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rmfw_pkg::req_type     req,
   output rmfw_pkg::ring_cmd_type ring_cmd,
   input  rmfw_pkg::tid_type     ring_rdata,
   output logic                  res_valid,
   input  logic                  res_ready,
   output rmfw_pkg::rsp_type     res
);
   import rmfw_pkg::*;

   fsm_type  state_ff, state_in;
   req_type  req_ff, req_in;
   logic     held_ff, held_in;
   tid_type  owner_ff, owner_in;
   nest_type nest_ff, nest_in;
   ptr_type  head_ff, head_in;
   ptr_type  tail_ff, tail_in;
   cnt_type  count_ff, count_in;

   // Decision for the item in hand
   logic     unlock, is_owner, q_write;
   logic     held_nx;
   tid_type  owner_nx;
   nest_type nest_nx;
   ptr_type  head_nx, tail_nx;
   cnt_type  count_nx;
   status_type status;
   logic     wv;
   tid_type  wt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         held_ff  <= 1'b0;
         owner_ff <= '0;
         nest_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         owner_ff <= owner_in;
         nest_ff  <= nest_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      req_ff <= req_in;
   end

   always_comb begin
      unlock   = req_ff.mode[UNLOCK_BIT];
      is_owner = (owner_ff == req_ff.thread_id);
      held_nx  = held_ff;
      owner_nx = owner_ff;
      nest_nx  = nest_ff;
      head_nx  = head_ff;
      tail_nx  = tail_ff;
      count_nx = count_ff;
      q_write  = 1'b0;
      wv       = 1'b0;
      wt       = '0;
      status   = ST_ACQUIRED;
      if (unlock) begin
         if (!held_ff) begin
            status = ST_NOT_LOCKED;
         end else if (!is_owner) begin
            status = ST_NOT_OWNER;
         end else if (nest_ff != '0) begin
            nest_nx = nest_ff - nest_type'(1);
            status  = ST_DROPPED;
         end else if (count_ff != '0) begin
            // hand over to the front waiter read on the accept cycle
            owner_nx = ring_rdata;
            nest_nx  = '0;
            head_nx  = ring_next(head_ff);
            count_nx = count_ff - cnt_type'(1);
            wv       = 1'b1;
            wt       = ring_rdata;
            status   = ST_RELEASED;
         end else begin
            held_nx = 1'b0;
            status  = ST_RELEASED;
         end
      end else if (!held_ff) begin
         held_nx  = 1'b1;
         owner_nx = req_ff.thread_id;
         nest_nx  = '0;
         status   = ST_ACQUIRED;
      end else if (is_owner) begin
         if (nest_ff == '1) begin
            status = ST_SATURATED;
         end else begin
            nest_nx = nest_ff + nest_type'(1);
            status  = ST_NESTED;
         end
      end else if (req_ff.mode == MODE_TRY) begin
         status = ST_BUSY;
      end else if (count_ff == cnt_type'(QUEUE_DEPTH)) begin
         status = ST_FULL;
      end else begin
         q_write  = 1'b1;
         tail_nx  = ring_next(tail_ff);
         count_nx = count_ff + cnt_type'(1);
         status   = ST_QUEUED;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      held_in  = held_ff;
      owner_in = owner_ff;
      nest_in  = nest_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      ring_cmd  = '0;
      ring_cmd.rd_addr = head_ff;
      ring_cmd.wr_addr = tail_ff;
      ring_cmd.wr_data = req_ff.thread_id;
      res.status       = status;
      res.woken_valid  = wv;
      res.woken_thread = wt;
      res.waiters_now  = count_nx;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ring_cmd.rd_en = 1'b1;
               req_in   = req;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            res_valid = 1'b1;
            if (res_ready) begin
               ring_cmd.wr_en = q_write;
               held_in  = held_nx;
               owner_in = owner_nx;
               nest_in  = nest_nx;
               head_in  = head_nx;
               tail_in  = tail_nx;
               count_in = count_nx;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end
endmodule

FILE: sv/recursive_mutex_fifo_waiters_core.sv
`timescale 1ns / 1ps
// Top level of the recursive lock unit: sequencer, wait ring and response register.
// Depends on rmfw_pkg, rmfw_ifs, rmfw_ram and rmfw_ctrl.

// Recursive lock with a first-in first-out wait queue. Each request beat
// carries a mode (lock, try-lock, unlock; the fourth code also unlocks) and a
// thread id, and yields exactly one response beat with a status code, the
// handed-over thread on a wake-up and the number of waiters left. On the
// accept cycle of a request the ring memory is read at the head pointer; on
// the next cycle the registered read data is used for the decision, and once
// the response register takes it the lock state is updated and, for a queued
// lock, the thread is written at the tail. A new request is accepted only
// after the last one is taken. The response register lets the next request
// be accepted while the last response still waits; a request is held in the
// decision state while that register is full and not being drained. Ring
// entries carry no reset: only entries previously written are ever handed over.
module recursive_mutex_fifo_waiters_core (
   input logic        clock,
   input logic        reset,
   rmfw_req_if.sink   req,
   rmfw_rsp_if.source rsp
);
   import rmfw_pkg::*;

   req_type      req_data;
   ring_cmd_type ring_cmd;
   tid_type      ring_rdata;
   logic         res_valid;
   logic         res_ready;
   rsp_type      res;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_data.mode      = req.mode;
   assign req_data.thread_id = req.thread_id;

   rmfw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req        (req_data),
      .ring_cmd   (ring_cmd),
      .ring_rdata (ring_rdata),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Wait ring: thread ids of queued lockers, head to tail
   rmfw_ram #(
      .WIDTH (THREAD_ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_cmd.wr_en),
      .wr_addr (ring_cmd.wr_addr),
      .wr_data (ring_cmd.wr_data),
      .rd_en   (ring_cmd.rd_en),
      .rd_addr (ring_cmd.rd_addr),
      .rd_data (ring_rdata)
   );

   // Response register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp.ready) begin
         // drop the beat once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_data_ff.status;
   assign rsp.woken_valid  = rsp_data_ff.woken_valid;
   assign rsp.woken_thread = rsp_data_ff.woken_thread;
   assign rsp.waiters_now  = rsp_data_ff.waiters_now;

   // An accepted request always has its decision ready on the next cycle
   a_decide_next: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> res_valid)
      else $error("no decision one cycle after an accepted request");

   // A wake-up only comes with a release
   a_wake_release: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.woken_valid) |-> (rsp.status == ST_RELEASED))
      else $error("woken thread reported without a release");

   // Without a wake-up the woken thread field reads zero
   a_wake_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.woken_valid) |-> (rsp.woken_thread == '0))
      else $error("woken thread not zero without a wake-up");

   // Waiter count never exceeds the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.waiters_now <= cnt_type'(QUEUE_DEPTH)))
      else $error("waiter count beyond ring depth");
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the recursive lock unit with its waiting queue.
// Depends on rmfw_pkg, rmfw_ifs and recursive_mutex_fifo_waiters_core.
module tb;
   import rmfw_pkg::*;

   // Bit 1 of the mode selects unlock, so both upper codes unlock.
   localparam logic [MODE_BITS-1:0] MODE_UNLOCK     = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_UNLOCK_ALT = 2'd3;

   localparam int PLAN_ROWS    = 19;
   localparam int RANDOM_BEATS = 160;
   localparam int CALM_BEATS   = 40;    // tail of the run with no idling at all
   localparam int POOL_SIZE    = 6;
   localparam int HOLD_OFF     = 200;   // long receiver stall, fills the block
   localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side
   localparam int SETTLE       = 16;
   localparam int REPORT_MAX   = 10;

   // Where a stimulus row takes its thread id from.
   typedef enum logic [1:0] {
      TID_FIXED,     // the id typed in the row
      TID_SCATTER,   // random, never zero (zero owns the lock when used)
      TID_OWNER      // whoever owns the lock once all earlier beats are in
   } tid_pick_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      tid_type              tid;
      logic [15:0]          reps;
      tid_pick_type         pick;
      logic                 typed;   // want holds the answer to expect
      rsp_type              want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   rmfw_req_if req_ch ();
   rmfw_rsp_if rsp_ch ();

   recursive_mutex_fifo_waiters_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Lock predictor: its own copy of the lock state, advanced once per
   // accepted request beat.
   // ---------------------------------------------------------------------
   logic        held_q;
   tid_type     owner_q;
   nest_type    levels_q;        // extra levels beyond the first
   tid_type     waiting_ring [QUEUE_DEPTH];
   int unsigned head_q;
   int unsigned tail_q;
   int unsigned waiting_q;
   int unsigned peak_waiting;

   rsp_type     due_answers [$];  // answers still owed by the block

   int          errors;
   int          reqs_accepted;
   int          directed_beats;
   int          rsp_seen;
   int          handovers;
   int          saturated_seen;
   int          full_seen;
   bit          gaps_on;
   bit          calm;

   function automatic rsp_type advance_lock(input logic [MODE_BITS-1:0] mode,
                                            input tid_type tid);
      rsp_type r;
      r = '0;
      if (mode[UNLOCK_BIT]) begin
         if (!held_q) begin
            r.status = ST_NOT_LOCKED;
         end else if (owner_q != tid) begin
            r.status = ST_NOT_OWNER;
         end else if (levels_q != '0) begin
            levels_q = levels_q - 1'b1;
            r.status = ST_DROPPED;
         end else if (waiting_q != 0) begin
            // hand over to the front waiter; it starts at a single level
            owner_q        = waiting_ring[head_q];
            levels_q       = '0;
            head_q         = (head_q + 1) % QUEUE_DEPTH;
            waiting_q      = waiting_q - 1;
            r.woken_valid  = 1'b1;
            r.woken_thread = owner_q;
            r.status       = ST_RELEASED;
         end else begin
            held_q   = 1'b0;
            r.status = ST_RELEASED;
         end
      end else if (!held_q) begin
         held_q   = 1'b1;
         owner_q  = tid;
         levels_q = '0;
         r.status = ST_ACQUIRED;
      end else if (owner_q == tid) begin
         if (levels_q == '1) begin
            r.status = ST_SATURATED;
         end else begin
            levels_q = levels_q + 1'b1;
            r.status = ST_NESTED;
         end
      end else if (mode == MODE_TRY) begin
         r.status = ST_BUSY;
      end else if (waiting_q >= QUEUE_DEPTH) begin
         r.status = ST_FULL;
      end else begin
         waiting_ring[tail_q] = tid;
         tail_q    = (tail_q + 1) % QUEUE_DEPTH;
         waiting_q = waiting_q + 1;
         r.status  = ST_QUEUED;
      end
      if (waiting_q > peak_waiting) peak_waiting = waiting_q;
      r.waiters_now = cnt_type'(waiting_q);
      return r;
   endfunction

   function automatic plan_row_type plan_row(input logic [MODE_BITS-1:0] mode,
                                             input tid_type tid, input int reps,
                                             input tid_pick_type pick,
                                             input logic typed,
                                             input status_type status,
                                             input logic woke, input tid_type woken,
                                             input int waiters);
      plan_row_type r;
      r.mode              = mode;
      r.tid               = tid;
      r.reps              = 16'(reps);
      r.pick              = pick;
      r.typed             = typed;
      r.want.status       = status;
      r.want.woken_valid  = woke;
      r.want.woken_thread = woken;
      r.want.waiters_now  = cnt_type'(waiters);
      return r;
   endfunction

   // Offer one request beat from a falling edge, hold it until accepted, then
   // record the answer it is owed. Returns at the next falling edge.
   task automatic offer_request(input logic [MODE_BITS-1:0] mode, input tid_type tid,
                                input logic typed, input rsp_type want);
      rsp_type predicted;
      if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.thread_id <= tid;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // the predictor always advances; a typed row overrides what is owed
      predicted = advance_lock(mode, tid);
      due_answers.push_back(typed ? want : predicted);
      reqs_accepted++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus: directed table first, then random traffic.
   // ---------------------------------------------------------------------
   initial begin : drive_requests
      plan_row_type plan_tbl [PLAN_ROWS];
      tid_type      pool [POOL_SIZE];
      tid_type      tid;
      logic [MODE_BITS-1:0] mode;
      int           pick;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_LOCK;
      req_ch.thread_id = '0;
      held_q           = 1'b0;
      owner_q          = '0;
      levels_q         = '0;
      head_q           = 0;
      tail_q           = 0;
      waiting_q        = 0;
      peak_waiting     = 0;
      errors           = 0;
      reqs_accepted    = 0;
      gaps_on          = 1'b1;
      calm             = 1'b0;

      // Free lock: unlocks are refused, by either unlock code.
      plan_tbl[0]  = plan_row(MODE_UNLOCK, 10'd5, 1, TID_FIXED, 1'b1,
                              ST_NOT_LOCKED, 1'b0, '0, 0);
      plan_tbl[1]  = plan_row(MODE_UNLOCK_ALT, 10'd1023, 1, TID_FIXED, 1'b1,
                              ST_NOT_LOCKED, 1'b0, '0, 0);
      // Try-lock takes a free lock; owner with nobody waiting frees it.
      plan_tbl[2]  = plan_row(MODE_TRY, 10'd1023, 1, TID_FIXED, 1'b1,
                              ST_ACQUIRED, 1'b0, '0, 0);
      plan_tbl[3]  = plan_row(MODE_UNLOCK_ALT, 10'd1023, 1, TID_FIXED, 1'b1,
                              ST_RELEASED, 1'b0, '0, 0);
      // Take the lock with id zero and nest it up to the saturation point.
      plan_tbl[4]  = plan_row(MODE_LOCK, 10'd0, 1, TID_FIXED, 1'b1,
                              ST_ACQUIRED, 1'b0, '0, 0);
      plan_tbl[5]  = plan_row(MODE_TRY, 10'd0, 1, TID_FIXED, 1'b1,
                              ST_NESTED, 1'b0, '0, 0);
      plan_tbl[6]  = plan_row(MODE_LOCK, 10'd0, 254, TID_FIXED, 1'b0,
                              ST_ACQUIRED, 1'b0, '0, 0);
      plan_tbl[7]  = plan_row(MODE_TRY, 10'd0, 1, TID_FIXED, 1'b1,
                              ST_SATURATED, 1'b0, '0, 0);
      plan_tbl[8]  = plan_row(MODE_LOCK, 10'd0, 1, TID_FIXED, 1'b1,
                              ST_SATURATED, 1'b0, '0, 0);
      // Another thread: refused by try-lock and by unlock, queued by lock.
      plan_tbl[9]  = plan_row(MODE_TRY, 10'd1023, 1, TID_FIXED, 1'b1,
                              ST_BUSY, 1'b0, '0, 0);
      plan_tbl[10] = plan_row(MODE_UNLOCK, 10'd1023, 1, TID_FIXED, 1'b1,
                              ST_NOT_OWNER, 1'b0, '0, 0);
      plan_tbl[11] = plan_row(MODE_LOCK, 10'd1023, 1, TID_FIXED, 1'b1,
                              ST_QUEUED, 1'b0, '0, 1);
      // same thread queued twice: each entry must be served on its own
      plan_tbl[12] = plan_row(MODE_LOCK, 10'd1023, 1, TID_FIXED, 1'b1,
                              ST_QUEUED, 1'b0, '0, 2);
      plan_tbl[13] = plan_row(MODE_LOCK, 10'd0, QUEUE_DEPTH - 2, TID_SCATTER, 1'b0,
                              ST_QUEUED, 1'b0, '0, 0);
      // Queue now full.
      plan_tbl[14] = plan_row(MODE_LOCK, 10'd512, 1, TID_FIXED, 1'b1,
                              ST_FULL, 1'b0, '0, QUEUE_DEPTH);
      plan_tbl[15] = plan_row(MODE_TRY, 10'd512, 1, TID_FIXED, 1'b1,
                              ST_BUSY, 1'b0, '0, QUEUE_DEPTH);
      // Unwind all nested levels, then hand over twice to the duplicate.
      plan_tbl[16] = plan_row(MODE_UNLOCK, 10'd0, 255, TID_FIXED, 1'b0,
                              ST_DROPPED, 1'b0, '0, 0);
      plan_tbl[17] = plan_row(MODE_UNLOCK, 10'd0, 1, TID_FIXED, 1'b1,
                              ST_RELEASED, 1'b1, 10'd1023, QUEUE_DEPTH - 1);
      plan_tbl[18] = plan_row(MODE_UNLOCK_ALT, 10'd0, 1, TID_OWNER, 1'b1,
                              ST_RELEASED, 1'b1, 10'd1023, QUEUE_DEPTH - 2);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) begin
         for (int k = 0; k < int'(plan_tbl[i].reps); k++) begin
            case (plan_tbl[i].pick)
               TID_SCATTER: tid = tid_type'($urandom_range(1, 1023));
               TID_OWNER:   tid = owner_q;
               default:     tid = plan_tbl[i].tid;
            endcase
            offer_request(plan_tbl[i].mode, tid, plan_tbl[i].typed, plan_tbl[i].want);
         end
      end
      directed_beats = reqs_accepted;

      // Random traffic: a small pool of threads contends, so the owner often
      // asks again and others queue; the owner unlocks often enough to keep
      // hand-overs going. Refresh the pool now and then so that every id bit
      // moves both ways.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0) begin
            for (int j = 0; j < POOL_SIZE; j++) pool[j] = tid_type'($urandom_range(0, 1023));
         end
         if (n % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         if (n >= RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
         pick = $urandom_range(0, 99);
         tid  = pool[$urandom_range(0, POOL_SIZE - 1)];
         if (held_q && pick < 45) begin
            mode = $urandom_range(0, 1) ? MODE_UNLOCK : MODE_UNLOCK_ALT;
            tid  = owner_q;
         end else if (pick < 75) begin
            mode = MODE_LOCK;
         end else if (pick < 90) begin
            mode = MODE_TRY;
         end else begin
            // stray unlock: often free lock or wrong thread
            mode = $urandom_range(0, 1) ? MODE_UNLOCK : MODE_UNLOCK_ALT;
         end
         offer_request(mode, tid, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      // Drain what is still owed, then give the block time to misbehave.
      while (due_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Run: %0d request beats (%0d directed), %0d hand-overs, peak of %0d waiters.",
               reqs_accepted, directed_beats, handovers, peak_waiting);
      $display("Answers seen: %0d, with %0d saturated and %0d queue-full.",
               rsp_seen, saturated_seen, full_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d failures found", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts in phases, one long hold-off early on so
   // that the request side backs up, and no stalls in the calm tail.
   // ---------------------------------------------------------------------
   initial begin : drive_ready
      int stall_left;
      int phase_left;
      bit stalls_on;
      bit pressed;
      stall_left   = 0;
      phase_left   = 0;
      stalls_on    = 1'b0;
      pressed      = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressed && reqs_accepted >= 60) begin
            pressed    = 1'b1;
            stall_left = HOLD_OFF;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (phase_left == 0) begin
               stalls_on  = ($urandom_range(0, 2) != 0);
               phase_left = 64;
            end
            phase_left--;
            if (stalls_on && !calm && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 10);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response check: every answer beat against the oldest one owed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_answers
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status       = rsp_ch.status;
         got.woken_valid  = rsp_ch.woken_valid;
         got.woken_thread = rsp_ch.woken_thread;
         got.waiters_now  = rsp_ch.waiters_now;
         rsp_seen++;
         if (got.woken_valid)            handovers++;
         if (got.status == ST_SATURATED) saturated_seen++;
         if (got.status == ST_FULL)      full_seen++;
         if (due_answers.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("%0t: answer beat with nothing owed: status %0d", $realtime,
                        got.status);
         end else begin
            want = due_answers.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display({"%0t: answer %0d: status %0d/%0d woken %0b/%0b ",
                            "thread %0d/%0d waiters %0d/%0d (expected/actual)"},
                           $realtime, rsp_seen, want.status, got.status,
                           want.woken_valid, got.woken_valid, want.woken_thread,
                           got.woken_thread, want.waiters_now, got.waiters_now);
            end
         end
      end
   end

   // Watchdog: end the run if neither side moves a beat for too long.
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d answers still owed", $realtime,
                  quiet, due_answers.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
